// File: hdl/itrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared types, constants and the digit symbol map for the radix text core.
// ----------------------------------------------------------------------------
package itrs_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int BASE_W          = 6;
    localparam int DIGIT_W         = 6;
    localparam int CHAR_W          = 8;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(35);
    localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

    typedef struct packed {
        logic              start;
        logic [BASE_W-1:0] base;
    } t_div_ctl;

    // 0-9 then a-z
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_DIGITS) begin
            return CHAR_ZERO + dx;
        end else begin
            return CHAR_LA + dx - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_DIGITS};
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/itrs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrs_if
// Valid/ready channels: input word (value, base) and output word (character).
// ----------------------------------------------------------------------------
interface itrs_in_if #(
    parameter int VALUE_WIDTH = itrs_pkg::VALUE_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [VALUE_WIDTH-1:0]   value;
    logic [itrs_pkg::BASE_W-1:0]     base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface

interface itrs_out_if;
    logic                            valid;
    logic                            ready;
    logic [itrs_pkg::CHAR_W-1:0]     character;
    logic                            last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// File: hdl/integer_to_radix_string_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_string_core
// Signed integer to ASCII text in radix 2..35, terminated by a flagged NUL.
// ----------------------------------------------------------------------------
// One input word at a time. Each digit comes from the bit-serial divider
// (one quotient bit per cycle); the text then leaves as any prefix and
// sign words, the digits (stack memory read, then output register) and the
// NUL word, each held while the output stalls. An out-of-range radix gives
// only the NUL word. Digits are kept in a VALUE_WIDTH-entry stack memory.
// ----------------------------------------------------------------------------
module integer_to_radix_string_core #(
    parameter int VALUE_WIDTH = itrs_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itrs_in_if.sink     i_in,
    itrs_out_if.source  o_out
);
    import itrs_pkg::*;

    localparam int AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int NW = $clog2(VALUE_WIDTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PFX0 = 3'd2;
    localparam logic [2:0] S_PFXX = 3'd3;
    localparam logic [2:0] S_SIGN = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_DIG  = 3'd6;
    localparam logic [2:0] S_TERM = 3'd7;

    logic [2:0]         r_state, n_state;
    logic               r_neg, r_hex;
    logic [BASE_W-1:0]  r_base;
    logic [NW-1:0]      r_cnt, n_cnt;
    logic [DIGIT_W-1:0] r_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0] r_rd;
    logic               r_ov;
    logic [CHAR_W-1:0]  r_och;
    logic               r_olast;

    logic                   in_acc;
    logic                   base_ok;
    logic [VALUE_WIDTH-1:0] v_u;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   slot_free;
    logic                   load;
    logic [CHAR_W-1:0]      ld_ch;
    logic                   ld_last;
    logic                   push;
    logic [NW-1:0]          rd_n;
    t_div_ctl               div_ctl;
    logic [VALUE_WIDTH-1:0] div_in;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [DIGIT_W-1:0]     div_rem;

    assign v_u       = i_in.value;
    assign mag       = v_u[VALUE_WIDTH-1] ? ((~v_u) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v_u;
    assign base_ok   = (i_in.base >= BASE_MIN) && (i_in.base <= BASE_MAX);
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc    = i_in.valid && i_in.ready;
    assign slot_free = !r_ov || o_out.ready;
    assign rd_n      = r_cnt - 1'b1;
    assign push      = (r_state == S_DIV) && div_done;
    assign div_in    = (r_state == S_IDLE) ? mag : div_quot;

    itrs_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_in),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        load          = 1'b0;
        ld_ch         = CHAR_NUL;
        ld_last       = 1'b0;
        div_ctl.start = 1'b0;
        div_ctl.base  = r_base;
        unique case (r_state)
            S_IDLE: begin
                div_ctl.base = i_in.base;
                if (in_acc) begin
                    n_cnt = '0;
                    if (base_ok) begin
                        div_ctl.start = 1'b1;
                        n_state       = S_DIV;
                    end else begin
                        n_state = S_TERM;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_cnt = r_cnt + 1'b1;
                    if (div_quot == '0) begin
                        n_state = r_hex ? S_PFX0 : (r_neg ? S_SIGN : S_RD);
                    end else begin
                        div_ctl.start = 1'b1;
                    end
                end
            end
            S_PFX0: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_ch   = CHAR_ZERO;
                    n_state = S_PFXX;
                end
            end
            S_PFXX: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_ch   = CHAR_X;
                    n_state = r_neg ? S_SIGN : S_RD;
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_ch   = CHAR_MINUS;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_cnt   = rd_n;
                n_state = S_DIG;
            end
            S_DIG: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_ch   = digit_char(r_rd);
                    n_state = (r_cnt == '0) ? S_TERM : S_RD;
                end
            end
            S_TERM: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_ch   = CHAR_NUL;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg  <= v_u[VALUE_WIDTH-1];
            r_hex  <= (i_in.base == BASE_HEX);
            r_base <= i_in.base;
        end
        if (load) begin
            r_och   <= ld_ch;
            r_olast <= ld_last;
        end
    end

    // digit stack
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_cnt[AW-1:0]] <= div_rem;
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[rd_n[AW-1:0]];
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.character = r_och;
    assign o_out.last      = r_olast;

`ifndef SYNTH
    a_last_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last |-> o_out.character == CHAR_NUL)
        else $error("last word carries a nonzero character");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(VALUE_WIDTH))
        else $error("digit stack overflow");

    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> r_state == S_DIV && !i_in.ready)
        else $error("digit pushed outside division");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.character))
        else $error("stalled output word changed");
`endif
endmodule
`default_nettype wire

// File: hdl/itrs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itrs_div
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
// ----------------------------------------------------------------------------
module itrs_div #(
    parameter int VALUE_WIDTH = itrs_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire itrs_pkg::t_div_ctl            i_ctl,
    input  wire logic [VALUE_WIDTH-1:0]        i_dividend,
    output logic                               o_done,
    output logic [VALUE_WIDTH-1:0]             o_quot,
    output logic [itrs_pkg::DIGIT_W-1:0]       o_rem
);
    import itrs_pkg::*;

    localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_WIDTH - 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_q;
    logic [DIGIT_W-1:0]     r_rem;
    logic [BASE_W-1:0]      r_base;

    logic [DIGIT_W:0] trial;
    logic [DIGIT_W:0] diff;
    logic             ge;

    assign trial = {r_rem, r_q[VALUE_WIDTH-1]};
    assign ge    = trial >= {1'b0, r_base};
    assign diff  = trial - {1'b0, r_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_base <= i_ctl.base;
        end else if (r_busy) begin
            r_q   <= {r_q[VALUE_WIDTH-2:0], ge};
            r_rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire
